FILE: design/tcrl_pkg.sv
// Package with types, register codes and constants of the twist command rate limiter.
package tcrl_pkg;

	localparam int VEL_W = 32;
	localparam int LIM_W = 31;
	localparam int STEP_W = 20;
	localparam int AGE_W = 32;
	localparam int OP_W = 33;
	localparam int PROD_W = 66;
	localparam int SQ_W = 64;
	localparam int ROOT_W = 32;
	localparam int CNT_W = 7;
	localparam int MUL_LEN = 33;
	localparam int DIV_LEN = 66;
	localparam int SQRT_LEN = 32;
	localparam int NUM_AXES = 3;
	localparam int AX_W = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [OP_W-1:0] US_PER_S = OP_W'(1000000);

	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TURN_RATE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_TURN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_US = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP_US = 3'd6;

	localparam logic [LIM_W-1:0] RST_MAX_SPEED = 31'd32768;
	localparam logic [LIM_W-1:0] RST_MAX_TURN_RATE = 31'd655360;
	localparam logic [LIM_W-1:0] RST_ACCEL_X = 31'd13107;
	localparam logic [LIM_W-1:0] RST_ACCEL_Y = 31'd13107;
	localparam logic [LIM_W-1:0] RST_ACCEL_TURN = 31'd655360;
	localparam logic [AGE_W-1:0] RST_TIMEOUT_US = 32'd1000000;
	localparam logic [STEP_W-1:0] RST_MAX_STEP_US = 20'd10000;

	localparam logic MODE_CMD = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	typedef struct packed {
		logic mode;
		logic signed [VEL_W-1:0] cmd_x;
		logic signed [VEL_W-1:0] cmd_y;
		logic signed [VEL_W-1:0] cmd_turn;
		logic [STEP_W-1:0] elapsed_us;
	} in_t;

	typedef struct packed {
		logic signed [VEL_W-1:0] out_x;
		logic signed [VEL_W-1:0] out_y;
		logic signed [VEL_W-1:0] out_turn;
		logic timed_out;
	} out_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CMD_SQX,
		ST_CMD_SQY,
		ST_CMD_SQRT,
		ST_CMD_LIM,
		ST_CMD_SCX_MUL,
		ST_CMD_SCX_DIV,
		ST_CMD_SCY_MUL,
		ST_CMD_SCY_DIV,
		ST_CMD_FIN,
		ST_TICK_AGE,
		ST_MD_MUL,
		ST_MD_DIV,
		ST_CMP_MUL1,
		ST_CMP_MUL2,
		ST_CMP_SEL,
		ST_UPD_MUL,
		ST_UPD_DIV,
		ST_OUT
	} state_t;

endpackage

FILE: design/twist_command_rate_limiter_unit.sv
// Top level of the twist command rate limiter with its bit-serial arithmetic sequencer.
// The block handles one item at a time and holds in_stall high while it works. A command
// takes longer when the speed limit scales the vector, and a tick that finds the command
// stale goes straight to the output; the time is set by one shared shift-add multiplier,
// one restoring divider and one square root unit, which the sequencer uses one operation
// after another. A tick result waits in an output register, so the next item is taken
// while that result is still pending.
module twist_command_rate_limiter_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  tcrl_pkg::in_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output tcrl_pkg::out_t out_data,
	input  logic cfg_we,
	input  logic [tcrl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tcrl_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tcrl_pkg::*;

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [AX_W-1:0] ax_q;

	logic [LIM_W-1:0] max_speed_q, max_turn_rate_q;
	logic [LIM_W-1:0] accel_q [NUM_AXES];
	logic [AGE_W-1:0] timeout_us_q, age_q;
	logic [STEP_W-1:0] max_step_us_q, step_q;

	in_t in_q;
	logic signed [VEL_W-1:0] tgt_q [NUM_AXES];
	logic signed [VEL_W-1:0] cur_q [NUM_AXES];
	logic [OP_W-1:0] n_q [NUM_AXES];
	logic [OP_W-1:0] d_q [NUM_AXES];
	logic [OP_W-1:0] bn_q, bd_q;
	logic [PROD_W-1:0] cmp_q;
	logic [SQ_W-1:0] sq_q;
	logic [ROOT_W-1:0] mag_q;
	logic timed_q;

	logic [OP_W-1:0] mul_a_q;
	logic [PROD_W-1:0] mul_p_q;
	logic [OP_W-1:0] div_den_q;
	logic [OP_W-1:0] div_rem_q;
	logic [PROD_W-1:0] div_q_q;
	logic [SQ_W-1:0] sq_s_q;
	logic [ROOT_W+1:0] sq_rem_q;
	logic [ROOT_W-1:0] sq_root_q;

	out_t out_q;
	logic out_valid_q;

	logic is_mul, is_div, is_sqrt, is_arith, last;
	logic [CNT_W-1:0] len;
	logic [OP_W-1:0] mul_a, mul_b, div_den;
	logic [OP_W-1:0] abs_x, abs_y;
	logic signed [OP_W-1:0] delta;
	logic [OP_W-1:0] abs_delta;
	logic [OP_W:0] mul_sum;
	logic [OP_W:0] div_sh;
	logic [OP_W+1:0] div_trial;
	logic [ROOT_W+3:0] sq_rs, sq_trial, sq_diff;
	logic [AGE_W:0] age_sum;
	logic [AGE_W-1:0] age_sat;
	logic [OP_W-1:0] quot;
	logic [OP_W-1:0] md;
	logic out_free;
	logic signed [OP_W-1:0] turn_e;

	assign abs_x = in_q.cmd_x[VEL_W-1] ? OP_W'(-{in_q.cmd_x[VEL_W-1], in_q.cmd_x})
		: {1'b0, in_q.cmd_x};
	assign abs_y = in_q.cmd_y[VEL_W-1] ? OP_W'(-{in_q.cmd_y[VEL_W-1], in_q.cmd_y})
		: {1'b0, in_q.cmd_y};
	assign delta = {tgt_q[ax_q][VEL_W-1], tgt_q[ax_q]} - {cur_q[ax_q][VEL_W-1], cur_q[ax_q]};
	assign abs_delta = delta[OP_W-1] ? OP_W'(-delta) : OP_W'(delta);
	assign age_sum = {1'b0, age_q} + {{(AGE_W-STEP_W+1){1'b0}}, in_q.elapsed_us};
	assign age_sat = age_sum[AGE_W] ? {AGE_W{1'b1}} : age_sum[AGE_W-1:0];
	assign quot = div_q_q[OP_W-1:0];
	assign md = quot;
	assign out_free = !out_valid_q || !out_stall;
	assign turn_e = {in_q.cmd_turn[VEL_W-1], in_q.cmd_turn};

	assign mul_sum = {1'b0, mul_p_q[PROD_W-1:OP_W]} + (mul_p_q[0] ? {1'b0, mul_a_q} : '0);
	assign div_sh = {div_rem_q, div_q_q[PROD_W-1]};
	assign div_trial = {1'b0, div_sh} - {2'b00, div_den_q};
	assign sq_rs = {sq_rem_q, sq_s_q[SQ_W-1:SQ_W-2]};
	assign sq_trial = {2'b00, sq_root_q, 2'b01};
	assign sq_diff = sq_rs - sq_trial;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		div_den = '0;
		case (state_q)
			ST_CMD_SQX: begin
				mul_a = abs_x;
				mul_b = abs_x;
			end
			ST_CMD_SQY: begin
				mul_a = abs_y;
				mul_b = abs_y;
			end
			ST_CMD_SCX_MUL: begin
				mul_a = abs_x;
				mul_b = {2'b00, max_speed_q};
			end
			ST_CMD_SCY_MUL: begin
				mul_a = abs_y;
				mul_b = {2'b00, max_speed_q};
			end
			ST_MD_MUL: begin
				mul_a = {2'b00, accel_q[ax_q]};
				mul_b = {{(OP_W-STEP_W){1'b0}}, step_q};
			end
			ST_CMP_MUL1: begin
				mul_a = n_q[ax_q];
				mul_b = bd_q;
			end
			ST_CMP_MUL2: begin
				mul_a = bn_q;
				mul_b = d_q[ax_q];
			end
			ST_UPD_MUL: begin
				mul_a = abs_delta;
				mul_b = bn_q;
			end
			ST_CMD_SCX_DIV, ST_CMD_SCY_DIV: div_den = {1'b0, mag_q};
			ST_MD_DIV: div_den = US_PER_S;
			ST_UPD_DIV: div_den = bd_q;
			default: ;
		endcase
	end

	always_comb begin
		is_mul = 1'b0;
		is_div = 1'b0;
		is_sqrt = 1'b0;
		case (state_q)
			ST_CMD_SQX, ST_CMD_SQY, ST_CMD_SCX_MUL, ST_CMD_SCY_MUL, ST_MD_MUL,
			ST_CMP_MUL1, ST_CMP_MUL2, ST_UPD_MUL: is_mul = 1'b1;
			ST_CMD_SCX_DIV, ST_CMD_SCY_DIV, ST_MD_DIV, ST_UPD_DIV: is_div = 1'b1;
			ST_CMD_SQRT: is_sqrt = 1'b1;
			default: ;
		endcase
		is_arith = is_mul || is_div || is_sqrt;
		len = is_div ? CNT_W'(DIV_LEN) : is_sqrt ? CNT_W'(SQRT_LEN) : CNT_W'(MUL_LEN);
		last = is_arith && (cnt_q == len + CNT_W'(1));
	end

	always_comb begin
		state_d = state_q;
		in_stall = state_q != ST_IDLE;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = in_data.mode == MODE_TICK ? ST_TICK_AGE : ST_CMD_SQX;
			ST_CMD_SQX: if (last) state_d = ST_CMD_SQY;
			ST_CMD_SQY: if (last) state_d = ST_CMD_SQRT;
			ST_CMD_SQRT: if (last) state_d = ST_CMD_LIM;
			ST_CMD_LIM: state_d = (mag_q != '0 && {1'b0, mag_q} > {2'b00, max_speed_q})
				? ST_CMD_SCX_MUL : ST_CMD_FIN;
			ST_CMD_SCX_MUL: if (last) state_d = ST_CMD_SCX_DIV;
			ST_CMD_SCX_DIV: if (last) state_d = ST_CMD_SCY_MUL;
			ST_CMD_SCY_MUL: if (last) state_d = ST_CMD_SCY_DIV;
			ST_CMD_SCY_DIV: if (last) state_d = ST_CMD_FIN;
			ST_CMD_FIN: state_d = ST_IDLE;
			ST_TICK_AGE: state_d = (age_sat > timeout_us_q) ? ST_OUT : ST_MD_MUL;
			ST_MD_MUL: if (last) state_d = ST_MD_DIV;
			ST_MD_DIV: if (last) state_d = (ax_q == AX_W'(NUM_AXES - 1)) ? ST_CMP_MUL1 : ST_MD_MUL;
			ST_CMP_MUL1: if (last) state_d = ST_CMP_MUL2;
			ST_CMP_MUL2: if (last) state_d = ST_CMP_SEL;
			ST_CMP_SEL: state_d = (ax_q == AX_W'(NUM_AXES - 1)) ? ST_UPD_MUL : ST_CMP_MUL1;
			ST_UPD_MUL: if (last) state_d = ST_UPD_DIV;
			ST_UPD_DIV: if (last) state_d = (ax_q == AX_W'(NUM_AXES - 1)) ? ST_OUT : ST_UPD_MUL;
			ST_OUT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
		cnt_d = (is_arith && !last) ? cnt_q + CNT_W'(1) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= RST_MAX_SPEED;
			max_turn_rate_q <= RST_MAX_TURN_RATE;
			accel_q[0] <= RST_ACCEL_X;
			accel_q[1] <= RST_ACCEL_Y;
			accel_q[2] <= RST_ACCEL_TURN;
			timeout_us_q <= RST_TIMEOUT_US;
			max_step_us_q <= RST_MAX_STEP_US;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_SPEED: max_speed_q <= cfg_data[LIM_W-1:0];
				REG_MAX_TURN_RATE: max_turn_rate_q <= cfg_data[LIM_W-1:0];
				REG_ACCEL_X: accel_q[0] <= cfg_data[LIM_W-1:0];
				REG_ACCEL_Y: accel_q[1] <= cfg_data[LIM_W-1:0];
				REG_ACCEL_TURN: accel_q[2] <= cfg_data[LIM_W-1:0];
				REG_TIMEOUT_US: timeout_us_q <= cfg_data[AGE_W-1:0];
				REG_MAX_STEP_US: max_step_us_q <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				tgt_q[i] <= '0;
				cur_q[i] <= '0;
			end
			age_q <= '0;
			ax_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_OUT) out_valid_q <= 1'b0;
			if (is_arith && cnt_q == '0) begin
				mul_a_q <= mul_a;
				mul_p_q <= {{OP_W{1'b0}}, mul_b};
				div_den_q <= div_den;
				div_rem_q <= '0;
				div_q_q <= mul_p_q;
				sq_s_q <= sq_q + mul_p_q[SQ_W-1:0];
				sq_rem_q <= '0;
				sq_root_q <= '0;
			end else if (is_arith && !last) begin
				if (is_mul) mul_p_q <= {mul_sum, mul_p_q[OP_W-1:1]};
				if (is_div) begin
					if (!div_trial[OP_W+1]) begin
						div_rem_q <= div_trial[OP_W-1:0];
						div_q_q <= {div_q_q[PROD_W-2:0], 1'b1};
					end else begin
						div_rem_q <= div_sh[OP_W-1:0];
						div_q_q <= {div_q_q[PROD_W-2:0], 1'b0};
					end
				end
				if (is_sqrt) begin
					sq_s_q <= {sq_s_q[SQ_W-3:0], 2'b00};
					if (sq_rs >= sq_trial) begin
						sq_rem_q <= sq_diff[ROOT_W+1:0];
						sq_root_q <= {sq_root_q[ROOT_W-2:0], 1'b1};
					end else begin
						sq_rem_q <= sq_rs[ROOT_W+1:0];
						sq_root_q <= {sq_root_q[ROOT_W-2:0], 1'b0};
					end
				end
			end
			case (state_q)
				ST_IDLE: if (in_valid) begin
					in_q <= in_data;
					sq_q <= '0;
					mul_p_q <= '0;
				end
				ST_CMD_SQX: if (last) sq_q <= mul_p_q[SQ_W-1:0];
				ST_CMD_SQRT: if (last) mag_q <= sq_root_q;
				ST_CMD_LIM: begin
					if (mag_q == '0) begin
						tgt_q[0] <= '0;
						tgt_q[1] <= '0;
					end else begin
						tgt_q[0] <= in_q.cmd_x;
						tgt_q[1] <= in_q.cmd_y;
					end
				end
				ST_CMD_SCX_DIV: if (last)
					tgt_q[0] <= in_q.cmd_x[VEL_W-1] ? -quot[VEL_W-1:0] : quot[VEL_W-1:0];
				ST_CMD_SCY_DIV: if (last)
					tgt_q[1] <= in_q.cmd_y[VEL_W-1] ? -quot[VEL_W-1:0] : quot[VEL_W-1:0];
				ST_CMD_FIN: begin
					if (turn_e > $signed({2'b00, max_turn_rate_q}))
						tgt_q[2] <= {1'b0, max_turn_rate_q};
					else if (turn_e < -$signed({2'b00, max_turn_rate_q}))
						tgt_q[2] <= -{1'b0, max_turn_rate_q};
					else
						tgt_q[2] <= in_q.cmd_turn;
					age_q <= '0;
				end
				ST_TICK_AGE: begin
					age_q <= age_sat;
					step_q <= (in_q.elapsed_us < max_step_us_q) ? in_q.elapsed_us : max_step_us_q;
					ax_q <= '0;
					if (age_sat > timeout_us_q) begin
						timed_q <= 1'b1;
						for (int i = 0; i < NUM_AXES; i++) cur_q[i] <= '0;
					end else begin
						timed_q <= 1'b0;
					end
				end
				ST_MD_DIV: if (last) begin
					if (md == '0 || abs_delta <= md) begin
						n_q[ax_q] <= OP_W'(1);
						d_q[ax_q] <= OP_W'(1);
						if (ax_q == '0) begin
							bn_q <= OP_W'(1);
							bd_q <= OP_W'(1);
						end
					end else begin
						n_q[ax_q] <= md;
						d_q[ax_q] <= abs_delta;
						if (ax_q == '0) begin
							bn_q <= md;
							bd_q <= abs_delta;
						end
					end
					ax_q <= (ax_q == AX_W'(NUM_AXES - 1)) ? AX_W'(1) : ax_q + AX_W'(1);
				end
				ST_CMP_MUL1: if (last) cmp_q <= mul_p_q;
				ST_CMP_SEL: begin
					if (cmp_q < mul_p_q) begin
						bn_q <= n_q[ax_q];
						bd_q <= d_q[ax_q];
					end
					ax_q <= (ax_q == AX_W'(NUM_AXES - 1)) ? '0 : ax_q + AX_W'(1);
				end
				ST_UPD_DIV: if (last) begin
					cur_q[ax_q] <= cur_q[ax_q] + (delta[OP_W-1] ? -quot[VEL_W-1:0] : quot[VEL_W-1:0]);
					ax_q <= (ax_q == AX_W'(NUM_AXES - 1)) ? '0 : ax_q + AX_W'(1);
				end
				ST_OUT: if (out_free) begin
					out_q.out_x <= cur_q[0];
					out_q.out_y <= cur_q[1];
					out_q.out_turn <= cur_q[2];
					out_q.timed_out <= timed_q;
					out_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DIV_LEN + 1))
		else $error("step counter ran past the longest operation");

	a_timeout_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.timed_out) |-> (out_data.out_x == '0 &&
		out_data.out_y == '0 && out_data.out_turn == '0))
		else $error("stale result carries a nonzero velocity");

	a_fraction: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD_MUL || state_q == ST_UPD_DIV) |-> (bd_q != '0 && bn_q <= bd_q))
		else $error("common fraction is above one or has a zero denominator");

endmodule

FILE: sim/twist_command_rate_limiter_unit_test.sv
// Testbench of the twist command rate limiter: directed and random transfers checked against a predictor.
`timescale 1ns / 100ps

module twist_command_rate_limiter_unit_test;
	import tcrl_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int IDLE_LIMIT = 12000;
	localparam int SETTLE_CYCLES = 1000;
	localparam int HOLD_CYCLES = 3000;
	localparam logic signed [VEL_W-1:0] VEL_MAX = 32'sh7FFFFFFF;
	localparam logic signed [VEL_W-1:0] VEL_MIN = 32'sh80000000;

	class shaper_scoreboard;
		logic [31:0] max_speed, max_turn, acc_x, acc_y, acc_turn, timeout, max_step;
		logic signed [31:0] tgt_x, tgt_y, tgt_turn, cur_x, cur_y, cur_turn;
		logic [31:0] age;
		out_t shaped_q[$];
		int errors;

		function new();
			max_speed = 32'(RST_MAX_SPEED);
			max_turn = 32'(RST_MAX_TURN_RATE);
			acc_x = 32'(RST_ACCEL_X);
			acc_y = 32'(RST_ACCEL_Y);
			acc_turn = 32'(RST_ACCEL_TURN);
			timeout = RST_TIMEOUT_US;
			max_step = 32'(RST_MAX_STEP_US);
			tgt_x = 0; tgt_y = 0; tgt_turn = 0;
			cur_x = 0; cur_y = 0; cur_turn = 0;
			age = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
			case (idx)
				REG_MAX_SPEED: max_speed = val & 32'h7FFFFFFF;
				REG_MAX_TURN_RATE: max_turn = val & 32'h7FFFFFFF;
				REG_ACCEL_X: acc_x = val & 32'h7FFFFFFF;
				REG_ACCEL_Y: acc_y = val & 32'h7FFFFFFF;
				REG_ACCEL_TURN: acc_turn = val & 32'h7FFFFFFF;
				REG_TIMEOUT_US: timeout = val;
				REG_MAX_STEP_US: max_step = val & 32'h000FFFFF;
				default: ;
			endcase
		endfunction

		function logic [63:0] root64(logic [63:0] v);
			logic [63:0] r, b;
			r = 0;
			b = 64'h4000000000000000;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else
					r >>= 1;
				b >>= 2;
			end
			return r;
		endfunction

		function logic signed [63:0] scale(logic signed [63:0] v, logic [127:0] num,
				logic [127:0] den);
			logic [127:0] m;
			m = (v < 0) ? 128'(-v) : 128'(v);
			m = m * num / den;
			return (v < 0) ? -$signed(m[63:0]) : $signed(m[63:0]);
		endfunction

		function void ratio(logic signed [63:0] delta, logic [31:0] acc, logic [31:0] st,
				output logic [127:0] n, output logic [127:0] d);
			logic [127:0] md, ad;
			md = 128'(acc) * 128'(st) / 128'(US_PER_S);
			ad = (delta < 0) ? 128'(-delta) : 128'(delta);
			if (md == 0 || ad <= md) begin
				n = 1;
				d = 1;
			end else begin
				n = md;
				d = ad;
			end
		endfunction

		function void note_input(in_t it);
			logic signed [63:0] x, y, t, lim, dx, dy, dt;
			logic [63:0] sq, mag, a;
			logic [31:0] st;
			logic [127:0] n, d, n2, d2;
			logic stale;
			out_t o;
			if (it.mode == MODE_CMD) begin
				x = $signed(it.cmd_x);
				y = $signed(it.cmd_y);
				t = $signed(it.cmd_turn);
				sq = x * x + y * y;
				mag = root64(sq);
				if (mag == 0) begin
					x = 0;
					y = 0;
				end else if (mag > 64'(max_speed)) begin
					x = scale(x, 128'(max_speed), 128'(mag));
					y = scale(y, 128'(max_speed), 128'(mag));
				end
				lim = $signed({32'b0, max_turn});
				if (t > lim) t = lim;
				if (t < -lim) t = -lim;
				tgt_x = 32'(x);
				tgt_y = 32'(y);
				tgt_turn = 32'(t);
				age = 0;
			end else begin
				a = 64'(age) + 64'(it.elapsed_us);
				st = (32'(it.elapsed_us) < max_step) ? 32'(it.elapsed_us) : max_step;
				age = (a > 64'hFFFFFFFF) ? 32'hFFFFFFFF : a[31:0];
				stale = age > timeout;
				if (stale) begin
					cur_x = 0;
					cur_y = 0;
					cur_turn = 0;
				end else begin
					dx = 64'(tgt_x) - 64'(cur_x);
					dy = 64'(tgt_y) - 64'(cur_y);
					dt = 64'(tgt_turn) - 64'(cur_turn);
					ratio(dx, acc_x, st, n, d);
					ratio(dy, acc_y, st, n2, d2);
					if (n2 * d < n * d2) begin
						n = n2;
						d = d2;
					end
					ratio(dt, acc_turn, st, n2, d2);
					if (n2 * d < n * d2) begin
						n = n2;
						d = d2;
					end
					cur_x = cur_x + 32'(scale(dx, n, d));
					cur_y = cur_y + 32'(scale(dy, n, d));
					cur_turn = cur_turn + 32'(scale(dt, n, d));
				end
				o.out_x = cur_x;
				o.out_y = cur_y;
				o.out_turn = cur_turn;
				o.timed_out = stale;
				shaped_q.push_back(o);
			end
		endfunction

		function void check_result(out_t got);
			out_t exp_o;
			if (shaped_q.size() == 0) begin
				$error("unexpected result transfer: out_x %0d", got.out_x);
				errors++;
				return;
			end
			exp_o = shaped_q.pop_front();
			if (got.out_x !== exp_o.out_x) begin
				$error("out_x expected %0d actual %0d", exp_o.out_x, got.out_x);
				errors++;
			end
			if (got.out_y !== exp_o.out_y) begin
				$error("out_y expected %0d actual %0d", exp_o.out_y, got.out_y);
				errors++;
			end
			if (got.out_turn !== exp_o.out_turn) begin
				$error("out_turn expected %0d actual %0d", exp_o.out_turn, got.out_turn);
				errors++;
			end
			if (got.timed_out !== exp_o.timed_out) begin
				$error("timed_out expected %0d actual %0d", exp_o.timed_out, got.timed_out);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_t in_data;
	logic out_valid;
	logic out_stall;
	out_t out_data;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	shaper_scoreboard sb;
	logic [31:0] cfg_vals[8];
	bit calm;
	bit hold_req;
	int idle_cycles;

	twist_command_rate_limiter_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 5);
		return $urandom_range(20, 300);
	endfunction

	function logic signed [31:0] pick_vel();
		logic signed [31:0] span;
		span = 5 * 65536;
		case ($urandom_range(0, 9))
			6, 7, 8: return $urandom;
			9: begin
				case ($urandom_range(0, 3))
					0: return VEL_MIN;
					1: return VEL_MAX;
					2: return 0;
					default: return -1;
				endcase
			end
			default: return $signed(32'($urandom_range(0, 2 * span))) - span;
		endcase
	endfunction

	function in_t make_item();
		in_t it;
		it.mode = ($urandom_range(0, 99) < 35) ? MODE_CMD : MODE_TICK;
		it.cmd_x = pick_vel();
		it.cmd_y = pick_vel();
		it.cmd_turn = pick_vel();
		case ($urandom_range(0, 9))
			0, 1: it.elapsed_us = STEP_W'($urandom_range(0, 1000));
			2: it.elapsed_us = STEP_W'($urandom);
			default: it.elapsed_us = STEP_W'($urandom_range(0, 15000));
		endcase
		return it;
	endfunction

	function void random_config();
		cfg_vals[REG_MAX_SPEED] = $urandom_range(0, 4 * 65536);
		cfg_vals[REG_MAX_TURN_RATE] = $urandom_range(0, 8 * 65536);
		cfg_vals[REG_ACCEL_X] = $urandom_range(0, 10 * 65536);
		cfg_vals[REG_ACCEL_Y] = $urandom_range(0, 10 * 65536);
		cfg_vals[REG_ACCEL_TURN] = ($urandom_range(0, 3) == 0) ? $urandom
			: $urandom_range(0, 20 * 65536);
		cfg_vals[REG_TIMEOUT_US] = ($urandom_range(0, 3) == 0) ? $urandom
			: $urandom_range(5000, 200000);
		cfg_vals[REG_MAX_STEP_US] = ($urandom_range(0, 4) == 0) ? $urandom
			: $urandom_range(1, 20000);
		cfg_vals[REG_UNUSED] = $urandom;
	endfunction

	task automatic send_item(in_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		sb.note_input(it);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.shaped_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs();
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= cfg_vals[i];
			@(posedge clk);
			sb.write_reg(CFG_IDX_W'(i), cfg_vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic send_random(int n);
		for (int i = 0; i < n; i++)
			send_item(make_item());
	endtask

	task automatic send_tick(int el);
		in_t it;
		it = make_item();
		it.mode = MODE_TICK;
		it.elapsed_us = STEP_W'(el);
		send_item(it);
	endtask

	task automatic send_cmd(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] t);
		in_t it;
		it = make_item();
		it.mode = MODE_CMD;
		it.cmd_x = x;
		it.cmd_y = y;
		it.cmd_turn = t;
		send_item(it);
	endtask

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int left;
		left = 0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (calm)
				out_stall <= 1'b0;
			else if (left > 0) begin
				left--;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 99) < 70)
				out_stall <= 1'b0;
			else begin
				left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 3)
					: $urandom_range(20, 300);
				out_stall <= 1'b1;
			end
		end
	end

	initial begin
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		hold_req = 1'b0;
		idle_cycles = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: zero vector, extreme commands, tiny and huge steps.
		send_cmd(0, 0, 0);
		send_tick(0);
		send_cmd(VEL_MAX, VEL_MAX, VEL_MAX);
		send_tick(10000);
		send_tick(20'hFFFFF);
		send_cmd(VEL_MIN, VEL_MIN, VEL_MIN);
		send_tick(1);
		send_tick(500);
		send_cmd(VEL_MIN, 0, VEL_MAX);
		send_tick(10000);
		send_cmd(3 * 65536, -4 * 65536, -20 * 65536);
		send_tick(10000);
		send_tick(10000);
		send_tick(0);
		send_tick(20'hFFFFF);
		send_tick(20'hFFFFF);
		settle();

		// Stale commands with a zero timeout and a long run of maximum steps.
		cfg_vals = '{32'h7FFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'd0, 32'hFFFFFFFF, 32'hFFFFFFFF};
		program_regs();
		calm = 1'b1;
		send_cmd(2 * 65536, -65536, 65536);
		for (int i = 0; i < 140; i++)
			send_tick(20'hFFFFF);
		calm = 1'b0;
		settle();
		cfg_vals[REG_TIMEOUT_US] = 32'hFFFFFFFF;
		program_regs();
		send_tick(20'hFFFFF);
		send_tick(100);
		send_random(150);
		settle();

		// All limits but the timeout at zero; zero acceleration means an unlimited axis.
		cfg_vals = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1000000, 32'd0, 32'd0};
		program_regs();
		send_random(80);
		settle();

		for (int ph = 0; ph < 6; ph++) begin
			random_config();
			program_regs();
			if (ph == 1)
				hold_req = 1'b1;
			calm = (ph == 3);
			send_random(110);
			calm = 1'b0;
			settle();
		end

		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
